// File: rtl/crcfc_pkg.sv
package crcfc_pkg;

   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned CRC_WIDTH = 16;
   localparam int unsigned POS_WIDTH = 4;
   localparam logic [POS_WIDTH-1:0] POS_FULL = 4'd8;
   localparam logic [POS_WIDTH-1:0] POS_LONG = 4'd7;
   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 16'hA001;
   localparam int unsigned LINE_DEPTH = 3;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_COUNT_WIDTH = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_BYTE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_BYTE = 1'b1;

   localparam logic [BYTE_WIDTH-1:0] START_BYTE_RESET = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0] END_BYTE_RESET = 8'h55;

   typedef enum logic [2:0] {
      KIND_START,
      KIND_DEVICE,
      KIND_COMMAND,
      KIND_LEN_LO,
      KIND_LEN_HI,
      KIND_BODY
   } kind_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] rx_byte;
      logic                  buffer_end;
   } req_word_type;

   typedef struct packed {
      logic                  payload_valid;
      logic [BYTE_WIDTH-1:0] payload_byte;
      logic                  frame_done;
      logic                  frame_ok;
      logic [BYTE_WIDTH-1:0] device_id;
      logic [BYTE_WIDTH-1:0] command_id;
      logic [CRC_WIDTH-1:0]  length_field;
   } rsp_word_type;

   typedef struct packed {
      kind_type              kind;
      logic                  line_full;
      logic                  long_enough;
      logic                  last;
      logic [BYTE_WIDTH-1:0] rx_byte;
   } class_word_type;

   function automatic logic [CRC_WIDTH-1:0] crc16_feed(
      input logic [CRC_WIDTH-1:0] crc,
      input logic [BYTE_WIDTH-1:0] data
   );
      logic [CRC_WIDTH-1:0] c;
      c = crc ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, data};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/crc16_frame_checker.sv
// Channel   Direction  Handshake              Word
// req_      in         req_valid / req_ready  rx_byte, buffer_end
// rsp_      out        rsp_valid / rsp_ready  payload and frame status
// csr_      in         csr_valid / csr_ready  register index and write data
//
// One word is taken per cycle while the queue has room; any result it causes passes
// the queue and then the back end's output register; the CRC update is combinational.
// Reset is synchronous and returns the frame state and the registers to their defaults.
// A two-entry queue separates the front and back ends, so a stalled result does not
// block input until the queue is full; csr_ready is always high.
module crc16_frame_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  crcfc_pkg::req_word_type               req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output crcfc_pkg::rsp_word_type               rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [crcfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [crcfc_pkg::BYTE_WIDTH-1:0]      csr_wdata
);
   import crcfc_pkg::*;

   logic [BYTE_WIDTH-1:0] start_byte_ff;
   logic [BYTE_WIDTH-1:0] start_byte_in;
   logic [BYTE_WIDTH-1:0] end_byte_ff;
   logic [BYTE_WIDTH-1:0] end_byte_in;
   logic                  push_valid;
   logic                  push_ready;
   class_word_type        push_word;
   logic                  pop_valid;
   logic                  pop_ready;
   class_word_type        pop_word;

   assign csr_ready = 1'b1;

   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in = end_byte_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_in = csr_wdata;
            CSR_END_BYTE: end_byte_in = csr_wdata;
            default: begin
               start_byte_in = start_byte_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff <= END_BYTE_RESET;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff <= end_byte_in;
      end
   end

   crcfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   crcfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   crcfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .start_byte (start_byte_ff),
      .end_byte   (end_byte_ff),
      .in_valid   (pop_valid),
      .in_ready   (pop_ready),
      .in_word    (pop_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

// File: rtl/crcfc_front.sv
module crcfc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  crcfc_pkg::req_word_type   req_word,
   output logic                  push_valid,
   input  logic                  push_ready,
   output crcfc_pkg::class_word_type push_word
);
   import crcfc_pkg::*;

   logic [POS_WIDTH-1:0] pos_ff;
   logic [POS_WIDTH-1:0] pos_in;
   logic                 accept;

   assign req_ready = push_ready;
   assign push_valid = req_valid;
   assign accept = req_valid && push_ready;

   always_comb begin
      push_word.rx_byte = req_word.rx_byte;
      push_word.last = req_word.buffer_end;
      push_word.line_full = (pos_ff == POS_FULL);
      push_word.long_enough = (pos_ff >= POS_LONG);
      case (pos_ff)
         4'd0: push_word.kind = KIND_START;
         4'd1: push_word.kind = KIND_DEVICE;
         4'd2: push_word.kind = KIND_COMMAND;
         4'd3: push_word.kind = KIND_LEN_LO;
         4'd4: push_word.kind = KIND_LEN_HI;
         default: push_word.kind = KIND_BODY;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_word.buffer_end) begin
            pos_in = '0;
         end else if (pos_ff < POS_FULL) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_FULL)
      else $error("Byte position ran past the full mark.");
   assert property (@(posedge clock) disable iff (reset)
      accept && req_word.buffer_end |=> pos_ff == '0)
      else $error("Byte position not cleared after the last word.");
   assert property (@(posedge clock) disable iff (reset)
      push_word.line_full |-> push_word.long_enough && push_word.kind == KIND_BODY)
      else $error("Inconsistent classification of a word.");

endmodule

// File: rtl/crcfc_queue.sv
module crcfc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  crcfc_pkg::class_word_type push_word,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output crcfc_pkg::class_word_type pop_word
);
   import crcfc_pkg::*;

   class_word_type                 slot_ff [QUEUE_DEPTH];
   logic                           wr_ptr_ff;
   logic                           wr_ptr_in;
   logic                           rd_ptr_ff;
   logic                           rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0]   count_ff;
   logic [QUEUE_COUNT_WIDTH-1:0]   count_in;
   logic                           do_push;
   logic                           do_pop;

   assign push_ready = (count_ff != QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("Queue count exceeds its depth.");
   assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 || count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH) ||
      wr_ptr_ff != rd_ptr_ff)
      else $error("Queue pointers disagree with the count.");
   assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Queue count missed a push.");

endmodule

// File: rtl/crcfc_back.sv
module crcfc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [crcfc_pkg::BYTE_WIDTH-1:0] start_byte,
   input  logic [crcfc_pkg::BYTE_WIDTH-1:0] end_byte,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  crcfc_pkg::class_word_type        in_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output crcfc_pkg::rsp_word_type          rsp_word
);
   import crcfc_pkg::*;

   logic [BYTE_WIDTH-1:0] line_ff [LINE_DEPTH];
   logic [BYTE_WIDTH-1:0] line_in [LINE_DEPTH];
   logic [CRC_WIDTH-1:0]  crc_ff;
   logic [CRC_WIDTH-1:0]  crc_in;
   logic                  start_ok_ff;
   logic                  start_ok_in;
   logic [BYTE_WIDTH-1:0] dev_ff;
   logic [BYTE_WIDTH-1:0] dev_in;
   logic [BYTE_WIDTH-1:0] cmd_ff;
   logic [BYTE_WIDTH-1:0] cmd_in;
   logic [CRC_WIDTH-1:0]  len_ff;
   logic [CRC_WIDTH-1:0]  len_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_word_type          rsp_word_ff;
   rsp_word_type          rsp_word_in;
   rsp_word_type          result;
   logic                  advance;
   logic                  emit;
   logic [BYTE_WIDTH-1:0] feed_byte;
   logic [CRC_WIDTH-1:0]  crc_fed;
   logic [CRC_WIDTH-1:0]  crc_mid;

   assign advance = in_valid && (!rsp_valid_ff || rsp_ready);
   assign in_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   assign feed_byte = in_word.line_full ? line_ff[0] : in_word.rx_byte;
   assign crc_fed = crc16_feed(crc_ff, feed_byte);
   assign crc_mid = in_word.line_full ? crc_fed : crc_ff;
   assign emit = in_word.line_full || in_word.last;

   always_comb begin
      result = '0;
      if (in_word.line_full) begin
         result.payload_valid = 1'b1;
         result.payload_byte = line_ff[0];
      end
      if (in_word.last) begin
         result.frame_done = 1'b1;
         result.frame_ok = in_word.long_enough && start_ok_ff &&
                           (in_word.rx_byte == end_byte) &&
                           ({line_ff[2], line_ff[1]} == crc_mid);
         result.device_id = dev_ff;
         result.command_id = cmd_ff;
         result.length_field = len_ff;
      end
   end

   always_comb begin
      line_in = line_ff;
      crc_in = crc_ff;
      start_ok_in = start_ok_ff;
      dev_in = dev_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      if (advance) begin
         if (in_word.last) begin
            for (int i = 0; i < LINE_DEPTH; i++) begin
               line_in[i] = '0;
            end
            crc_in = '0;
            start_ok_in = 1'b0;
            dev_in = '0;
            cmd_in = '0;
            len_in = '0;
         end else begin
            case (in_word.kind)
               KIND_START: begin
                  start_ok_in = (in_word.rx_byte == start_byte);
               end
               KIND_DEVICE: begin
                  crc_in = crc_fed;
                  dev_in = in_word.rx_byte;
               end
               KIND_COMMAND: begin
                  crc_in = crc_fed;
                  cmd_in = in_word.rx_byte;
               end
               KIND_LEN_LO: begin
                  crc_in = crc_fed;
                  len_in = {len_ff[CRC_WIDTH-1:BYTE_WIDTH], in_word.rx_byte};
               end
               KIND_LEN_HI: begin
                  crc_in = crc_fed;
                  len_in = {in_word.rx_byte, len_ff[BYTE_WIDTH-1:0]};
               end
               default: begin
                  crc_in = crc_mid;
                  for (int i = 0; i < LINE_DEPTH - 1; i++) begin
                     line_in[i] = line_ff[i+1];
                  end
                  line_in[LINE_DEPTH-1] = in_word.rx_byte;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      if (advance) begin
         rsp_valid_in = emit;
         rsp_word_in = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_DEPTH; i++) begin
            line_ff[i] <= '0;
         end
         crc_ff <= '0;
         start_ok_ff <= 1'b0;
         dev_ff <= '0;
         cmd_ff <= '0;
         len_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_ff <= line_in;
         crc_ff <= crc_in;
         start_ok_ff <= start_ok_in;
         dev_ff <= dev_in;
         cmd_ff <= cmd_in;
         len_ff <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.payload_valid || rsp_word_ff.frame_done)
      else $error("An empty result was offered.");
   assert property (@(posedge clock) disable iff (reset)
      advance && in_word.last |=> crc_ff == '0 && !start_ok_ff && len_ff == '0)
      else $error("Frame state not cleared after the last word.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.frame_ok |-> rsp_word_ff.frame_done)
      else $error("Frame status reported without the last word.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.frame_done |->
      rsp_word_ff.device_id == '0 && rsp_word_ff.length_field == '0)
      else $error("Header fields leaked into a payload-only result.");

endmodule

// File: sim/frame_check_monitor.sv
module frame_check_monitor
   import crcfc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  req_word_type                 req_word,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  rsp_word_type                 rsp_word,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [BYTE_WIDTH-1:0]        csr_wdata,
   output int                           error_count,
   output int                           awaited_count,
   output int                           results_seen,
   output int                           frames_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [BYTE_WIDTH-1:0] start_reg;
   logic [BYTE_WIDTH-1:0] end_reg;

   logic [POS_WIDTH-1:0]  seen_count;
   logic [BYTE_WIDTH-1:0] tail [LINE_DEPTH];
   logic [CRC_WIDTH-1:0]  crc_acc;
   logic                  start_good;
   logic [BYTE_WIDTH-1:0] dev_held;
   logic [BYTE_WIDTH-1:0] cmd_held;
   logic [CRC_WIDTH-1:0]  len_held;

   rsp_word_type awaited_rsp [$];
   int fault_total = 0;
   int result_total = 0;
   int frame_total = 0;

   function automatic logic [CRC_WIDTH-1:0] crc_after(
      input logic [CRC_WIDTH-1:0] crc,
      input logic [BYTE_WIDTH-1:0] data
   );
      logic [CRC_WIDTH-1:0] r;
      r = crc;
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         r = (r[0] ^ data[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   task automatic clear_frame();
      seen_count = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         tail[i] = '0;
      end
      crc_acc = '0;
      start_good = 1'b0;
      dev_held = '0;
      cmd_held = '0;
      len_held = '0;
   endtask

   task automatic note_fault(input string what, input logic [63:0] want,
                             input logic [63:0] got);
      fault_total++;
      if (fault_total <= 10) begin
         $display("%t: %s: expected %0h, got %0h", $realtime, what, want, got);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         note_fault({"mismatch on ", name}, want, got);
      end
   endtask

   // Advances the frame state by one received byte and queues any result word it causes.
   task automatic advance_frame(input req_word_type w);
      rsp_word_type          outcome;
      logic [POS_WIDTH-1:0]  p;
      logic [CRC_WIDTH-1:0]  carried_crc;
      outcome = '0;
      p = seen_count;
      if (p == POS_FULL) begin
         outcome.payload_valid = 1'b1;
         outcome.payload_byte = tail[0];
         crc_acc = crc_after(crc_acc, tail[0]);
      end
      if (w.buffer_end) begin
         carried_crc = {tail[2], tail[1]};
         outcome.frame_done = 1'b1;
         outcome.frame_ok = (p >= POS_LONG) && start_good && (w.rx_byte == end_reg)
                            && (carried_crc == crc_acc);
         outcome.device_id = dev_held;
         outcome.command_id = cmd_held;
         outcome.length_field = len_held;
         awaited_rsp.push_back(outcome);
         clear_frame();
      end else begin
         if (p == 0) begin
            start_good = (w.rx_byte == start_reg);
         end else if (p <= 4) begin
            crc_acc = crc_after(crc_acc, w.rx_byte);
            case (p)
               1: dev_held = w.rx_byte;
               2: cmd_held = w.rx_byte;
               3: len_held[7:0] = w.rx_byte;
               default: len_held[15:8] = w.rx_byte;
            endcase
         end else begin
            tail[0] = tail[1];
            tail[1] = tail[2];
            tail[2] = w.rx_byte;
         end
         if (p < POS_FULL) begin
            seen_count = p + 1'b1;
         end
         if (outcome.payload_valid) begin
            awaited_rsp.push_back(outcome);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         start_reg = START_BYTE_RESET;
         end_reg = END_BYTE_RESET;
         clear_frame();
         awaited_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_BYTE) begin
               start_reg = csr_wdata;
            end else if (csr_index == CSR_END_BYTE) begin
               end_reg = csr_wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            result_total++;
            if (rsp_word.frame_done) begin
               frame_total++;
            end
            if (awaited_rsp.size() == 0) begin
               note_fault("result word with none awaited", '0, rsp_word);
            end else begin
               want = awaited_rsp.pop_front();
               compare_field("payload_valid", want.payload_valid, rsp_word.payload_valid);
               compare_field("payload_byte", want.payload_byte, rsp_word.payload_byte);
               compare_field("frame_done", want.frame_done, rsp_word.frame_done);
               compare_field("frame_ok", want.frame_ok, rsp_word.frame_ok);
               compare_field("device_id", want.device_id, rsp_word.device_id);
               compare_field("command_id", want.command_id, rsp_word.command_id);
               compare_field("length_field", want.length_field, rsp_word.length_field);
            end
         end
         if (req_valid && req_ready) begin
            advance_frame(req_word);
         end
      end
      error_count <= fault_total;
      awaited_count <= awaited_rsp.size();
      results_seen <= result_total;
      frames_seen <= frame_total;
   end

endmodule

// File: sim/tb_top.sv
module tb_top
   import crcfc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      FLAW_NONE,
      FLAW_START,
      FLAW_END,
      FLAW_CRC,
      FLAW_NOISE
   } flaw_kind;

   logic clock = 1'b0;
   logic reset;

   logic                        req_valid;
   logic                        req_ready;
   req_word_type                req_word;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   rsp_word_type                rsp_word;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [BYTE_WIDTH-1:0]       csr_wdata;

   int error_count;
   int awaited_count;
   int results_seen;
   int frames_seen;

   int send_gap_pct = 18;
   int hold_pct = 59;
   int bytes_sent = 0;
   int buffers_sent = 0;
   logic [BYTE_WIDTH-1:0] cfg_start;
   logic [BYTE_WIDTH-1:0] cfg_end;

   crc16_frame_checker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_check_monitor u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .awaited_count (awaited_count),
      .results_seen  (results_seen),
      .frames_seen   (frames_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= hold_pct);
   end

   function automatic logic [CRC_WIDTH-1:0] frame_crc(input logic [BYTE_WIDTH-1:0] q[$]);
      logic [CRC_WIDTH-1:0] c;
      c = '0;
      for (int k = 1; k < q.size(); k++) begin
         c = c ^ {8'h00, q[k]};
         repeat (BYTE_WIDTH) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
      end
      return c;
   endfunction

   task automatic send_word(input logic [BYTE_WIDTH-1:0] b, input logic is_end);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{rx_byte: b, buffer_end: is_end};
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [BYTE_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      if (idx == CSR_START_BYTE) begin
         cfg_start = data;
      end else begin
         cfg_end = data;
      end
      @(posedge clock);
   endtask

   // Drops valid, waits for every awaited word, then lets the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic send_frame(input logic [BYTE_WIDTH-1:0] dev,
                             input logic [BYTE_WIDTH-1:0] cmd,
                             input logic [CRC_WIDTH-1:0] len,
                             input int n_payload, input flaw_kind flaw, input int cut);
      logic [BYTE_WIDTH-1:0] bytes_q[$];
      logic [CRC_WIDTH-1:0]  crc;
      int                    at;
      bytes_q.push_back(cfg_start);
      bytes_q.push_back(dev);
      bytes_q.push_back(cmd);
      bytes_q.push_back(len[7:0]);
      bytes_q.push_back(len[15:8]);
      repeat (n_payload) bytes_q.push_back(8'($urandom));
      crc = frame_crc(bytes_q);
      bytes_q.push_back(crc[7:0]);
      bytes_q.push_back(crc[15:8]);
      bytes_q.push_back(cfg_end);
      case (flaw)
         FLAW_START: bytes_q[0] = bytes_q[0] ^ 8'($urandom_range(1, 255));
         FLAW_END: begin
            at = bytes_q.size() - 1;
            bytes_q[at] = bytes_q[at] ^ 8'($urandom_range(1, 255));
         end
         FLAW_CRC: begin
            at = bytes_q.size() - 3 + $urandom_range(1);
            bytes_q[at] = bytes_q[at] ^ 8'($urandom_range(1, 255));
         end
         FLAW_NOISE: begin
            bytes_q.delete();
            repeat ($urandom_range(1, 20)) bytes_q.push_back(8'($urandom));
         end
         default: ;
      endcase
      if (cut > 0) begin
         while (bytes_q.size() > cut) begin
            void'(bytes_q.pop_back());
         end
         bytes_q[cut-1] = cfg_end;
      end
      for (int k = 0; k < bytes_q.size(); k++) begin
         send_word(bytes_q[k], k == bytes_q.size() - 1);
      end
      buffers_sent++;
   endtask

   task automatic random_frames(input int count);
      int       goal;
      int       pick;
      int       n;
      int       cut;
      flaw_kind flaw;
      logic [CRC_WIDTH-1:0] len;
      goal = bytes_sent + count;
      while (bytes_sent < goal) begin
         pick = $urandom_range(99);
         n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 6);
         len = $urandom_range(1) ? 16'(n) : 16'($urandom);
         flaw = (pick < 60) ? FLAW_NONE : (pick < 70) ? FLAW_START : (pick < 78) ? FLAW_END :
                (pick < 90) ? FLAW_CRC : FLAW_NOISE;
         cut = ($urandom_range(99) < 10) ? $urandom_range(1, 7) : 0;
         send_frame(8'($urandom), 8'($urandom), len, n, flaw, cut);
      end
   endtask

   initial begin
      logic [BYTE_WIDTH-1:0] pick_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = CSR_START_BYTE;
      csr_wdata = '0;
      cfg_start = START_BYTE_RESET;
      cfg_end = END_BYTE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_frame(8'hFF, 8'h00, 16'hFFFF, 0, FLAW_NONE, 0);
      send_frame(8'h00, 8'hFF, 16'h0000, 1, FLAW_START, 0);
      send_frame(8'h5A, 8'hA5, 16'h0001, 0, FLAW_NONE, 1);
      send_frame(8'h12, 8'h34, 16'h0100, 0, FLAW_NONE, 7);
      random_frames(100);
      settle();

      send_gap_pct = 59;
      hold_pct = 18;
      write_reg(CSR_START_BYTE, 8'h00);
      write_reg(CSR_END_BYTE, 8'hFF);
      random_frames(100);
      settle();

      send_gap_pct = 0;
      hold_pct = 0;
      write_reg(CSR_START_BYTE, 8'hFF);
      write_reg(CSR_END_BYTE, 8'h00);
      random_frames(100);
      settle();

      pick_start = $urandom;
      write_reg(CSR_START_BYTE, pick_start);
      write_reg(CSR_END_BYTE, $urandom_range(1) ? pick_start : 8'($urandom));
      random_frames(100);
      settle();

      $display("Checked %0d result words, %0d of them frame reports, from %0d bytes",
               results_seen, frames_seen, bytes_sent);
      $display("in %0d buffers under four start/end settings and three idling mixes.",
               buffers_sent);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
